// ----- hdl/trd_pkg.sv -----
package trd_pkg;

    localparam int unsigned PADDR_WIDTH = 3;

    localparam logic [2:0]  PIXEL_BYTES_RESET  = 3'd4;
    localparam logic [31:0] IMAGE_PIXELS_RESET = 32'd1;

    localparam logic [7:0] RUN_THRESHOLD = 8'd128;
    localparam logic [7:0] RUN_OFFSET    = 8'd127;

    localparam logic REG_PIXEL_BYTES  = 1'b0;
    localparam logic REG_IMAGE_PIXELS = 1'b1;

    typedef struct packed {
        logic [2:0]  pixel_bytes;
        logic [31:0] image_pixels;
    } trd_cfg_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        image_done;
        logic        overflow_error;
    } trd_result_t;

endpackage

// ----- hdl/trd_if.sv -----
interface trd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

interface trd_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        overflow_error;

    modport source (output valid, output pixel_value, output repeat_count,
                    output image_done, output overflow_error, input ready);
    modport sink (input valid, input pixel_value, input repeat_count,
                  input image_done, input overflow_error, output ready);
endinterface

// ----- hdl/trd_cfg_regs.sv -----
module trd_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trd_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output trd_pkg::trd_cfg_t               cfg
);

    logic [2:0]  pixel_bytes_reg;
    logic [31:0] image_pixels_reg;
    logic        wr_en;
    logic        reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg  <= trd_pkg::PIXEL_BYTES_RESET;
            image_pixels_reg <= trd_pkg::IMAGE_PIXELS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                trd_pkg::REG_PIXEL_BYTES:  pixel_bytes_reg  <= pwdata[2:0];
                trd_pkg::REG_IMAGE_PIXELS: image_pixels_reg <= pwdata;
                default:                   pixel_bytes_reg  <= pixel_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            trd_pkg::REG_PIXEL_BYTES:  prdata = {29'd0, pixel_bytes_reg};
            trd_pkg::REG_IMAGE_PIXELS: prdata = image_pixels_reg;
            default:                   prdata = '0;
        endcase
    end

    assign cfg.pixel_bytes  = pixel_bytes_reg;
    assign cfg.image_pixels = image_pixels_reg;

endmodule

// ----- hdl/trd_core.sv -----
module trd_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            code_byte,
    input  trd_pkg::trd_cfg_t     cfg,
    output logic                  res_valid,
    output trd_pkg::trd_result_t  res
);

    localparam logic [1:0] PHASE_HEADER = 2'd0;
    localparam logic [1:0] PHASE_RAW    = 2'd1;
    localparam logic [1:0] PHASE_RUN    = 2'd2;

    logic [1:0]  phase_reg,            phase_next;
    logic [7:0]  packet_remaining_reg, packet_remaining_next;
    logic [1:0]  byte_position_reg,    byte_position_next;
    logic [31:0] pixel_assembly_reg,   pixel_assembly_next;
    logic [31:0] pixels_emitted_reg,   pixels_emitted_next;

    logic        in_packet;
    logic [1:0]  last_position;
    logic [31:0] assembled;
    logic [31:0] left;
    logic [7:0]  rep_packet;
    logic [31:0] rep;
    logic        done;
    logic        ovf;

    always_comb
    begin
        if (cfg.pixel_bytes == 3'd0)
        begin
            last_position = 2'd0;
        end
        else if (cfg.pixel_bytes > 3'd4)
        begin
            last_position = 2'd3;
        end
        else
        begin
            last_position = 2'(cfg.pixel_bytes - 3'd1);
        end
    end

    assign in_packet  = (phase_reg == PHASE_RAW) || (phase_reg == PHASE_RUN);
    assign assembled  = pixel_assembly_reg
                      | ({24'd0, code_byte} << {byte_position_reg, 3'b000});
    assign left       = (cfg.image_pixels > pixels_emitted_reg)
                      ? cfg.image_pixels - pixels_emitted_reg : 32'd0;
    assign rep_packet = (phase_reg == PHASE_RAW) ? 8'd1 : packet_remaining_reg;
    assign rep        = ({24'd0, rep_packet} > left) ? left : {24'd0, rep_packet};
    assign done       = (rep == left);
    assign ovf        = done && ({24'd0, packet_remaining_reg} > rep);

    always_comb
    begin
        phase_next            = phase_reg;
        packet_remaining_next = packet_remaining_reg;
        byte_position_next    = byte_position_reg;
        pixel_assembly_next   = pixel_assembly_reg;
        pixels_emitted_next   = pixels_emitted_reg;
        res_valid             = 1'b0;
        res.pixel_value       = assembled;
        res.repeat_count      = rep[7:0];
        res.image_done        = done;
        res.overflow_error    = ovf;

        if (step)
        begin
            if (!in_packet)
            begin
                if (code_byte < trd_pkg::RUN_THRESHOLD)
                begin
                    phase_next            = PHASE_RAW;
                    packet_remaining_next = code_byte + 8'd1;
                end
                else
                begin
                    phase_next            = PHASE_RUN;
                    packet_remaining_next = code_byte - trd_pkg::RUN_OFFSET;
                end
                byte_position_next  = 2'd0;
                pixel_assembly_next = 32'd0;
            end
            else if (byte_position_reg < last_position)
            begin
                pixel_assembly_next = assembled;
                byte_position_next  = byte_position_reg + 2'd1;
            end
            else
            begin
                res_valid           = 1'b1;
                byte_position_next  = 2'd0;
                pixel_assembly_next = 32'd0;
                if (done)
                begin
                    pixels_emitted_next   = 32'd0;
                    packet_remaining_next = 8'd0;
                    phase_next            = PHASE_HEADER;
                end
                else
                begin
                    pixels_emitted_next = pixels_emitted_reg + rep;
                    if ((phase_reg == PHASE_RAW) && (packet_remaining_reg > 8'd1))
                    begin
                        packet_remaining_next = packet_remaining_reg - 8'd1;
                    end
                    else
                    begin
                        packet_remaining_next = 8'd0;
                        phase_next            = PHASE_HEADER;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PHASE_HEADER;
            packet_remaining_reg <= 8'd0;
            byte_position_reg    <= 2'd0;
            pixel_assembly_reg   <= 32'd0;
            pixels_emitted_reg   <= 32'd0;
        end
        else
        begin
            phase_reg            <= phase_next;
            packet_remaining_reg <= packet_remaining_next;
            byte_position_reg    <= byte_position_next;
            pixel_assembly_reg   <= pixel_assembly_next;
            pixels_emitted_reg   <= pixels_emitted_next;
        end
    end

    // A header byte never completes a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && !in_packet) |-> !res_valid)
        else $error("result produced from a packet header");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.overflow_error) |-> res.image_done)
        else $error("overflow flagged without image completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.image_done) |=>
            (pixels_emitted_reg == 32'd0) && (phase_reg == PHASE_HEADER))
        else $error("counters not restarted after image completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.image_done) |=>
            (pixels_emitted_reg == $past(pixels_emitted_reg) + $past(rep)))
        else $error("pixel count not advanced by repeat count");

endmodule

// ----- hdl/tga_rle_pixel_decoder_unit.sv -----
// TGA run-length pixel decoder.
// The input channel carries the coded stream one byte per item: packet headers
// and pixel bytes in file order. The output channel carries one item per
// completed pixel with its value, repeat count, an end-of-image mark and an
// overflow mark. Pixel size and image size are set through the APB port; the
// user must do so only while the block is idle, which the block does not
// enforce. Register 0 is pixel_bytes, register 1 image_pixels. A byte is taken
// into an input register, decoded by one pass of logic against the packet and
// pixel counters, and its result lands in an output register. Throughput is
// one byte per cycle while the output is not stalled; it is set by the single
// update of the packet and pixel counters.
// Reset clears the counters, drops any held byte and result, and loads the
// registers with four bytes per pixel and a one-pixel image.
// When the receiver stalls, the result is held, one more byte can be taken
// into the input register, and the input then stops accepting until the
// result is taken.
module tga_rle_pixel_decoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trd_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    trd_byte_if.sink                        in_ch,
    trd_pixel_if.source                     out_ch
);

    trd_pkg::trd_cfg_t    cfg;
    trd_pkg::trd_result_t res;
    trd_pkg::trd_result_t out_data_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       advance;
    logic       res_valid;

    trd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.code_byte;
        end
    end

    trd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .code_byte (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pixel_value    = out_data_reg.pixel_value;
    assign out_ch.repeat_count   = out_data_reg.repeat_count;
    assign out_ch.image_done     = out_data_reg.image_done;
    assign out_ch.overflow_error = out_data_reg.overflow_error;

endmodule
